// ----- design/smpq_pkg.sv -----
// ============================================================================
// smpq_pkg
// Shared codes and field widths for the stable minimum priority queue.
// ============================================================================
`default_nettype none

package smpq_pkg;

    // Fixed widths of the stream fields.
    localparam int FIELD_BITS  = 16;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 5;
    localparam int IN_TDATA_BITS  = 32;
    localparam int OUT_TDATA_BITS = 40;

    // Request kinds carried in s_tuser.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    // Result status codes carried in m_tuser.
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ----- design/smpq_ram.sv -----
// ============================================================================
// smpq_ram
// Simple dual-port entry store: one write port, one read port with a
// registered read.
// ============================================================================
`default_nettype none

module smpq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/stable_min_priority_queue.sv -----
// ============================================================================
// stable_min_priority_queue
// Bounded, stable minimum priority queue kept as a sorted ring in one RAM.
// ============================================================================
//
//  Channel  Direction  Signals                     Contents
//  -------  ---------  --------------------------  ------------------------------
//  s_*      in         tvalid tready tdata tuser   insert or pop request
//  m_*      out        tvalid tready tdata tuser   status, popped entry, occupancy
//
//  The entries live in a ring buffer in a single RAM, sorted from the head
//  (smallest key, earliest arrival) to the tail. A pop reads the head entry
//  and advances the head pointer. An insert walks the ring backward from
//  the tail through the single read port, moving every entry with a larger
//  key one slot up, and drops the new entry into the hole; into an empty
//  queue it is written straight to the tail. Refused requests (pop while
//  empty, insert while full) answer straight from the idle state.
//  Reset clears the state, the pointers, the count and the output valid
//  flag; the RAM needs no clearing, since only slots between head and tail
//  are ever read. A finished result sits in the output register until
//  m_tready; a result that finds it still full parks in a pending register,
//  and new requests are taken only while the sequencer is idle.
`default_nettype none

module stable_min_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, lowest bit up: priority_req[15:0], item_handle[31:16]
    input  wire logic [31:0] s_tdata,
    // s_tuser: mode[0]
    input  wire logic [0:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, lowest bit up: out_handle[15:0], out_priority[31:16],
    // occupancy[36:32], zero fill[39:37]
    output logic      [39:0] m_tdata,
    // m_tuser: status[1:0]
    output logic      [1:0]  m_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = KEY_BITS + HANDLE_BITS;
    localparam int FW = smpq_pkg::FIELD_BITS;
    localparam int SW = smpq_pkg::STATUS_BITS;
    localparam int OW = smpq_pkg::OCC_BITS;

    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] S_POP  = 3'd1;  // head entry arrives from the RAM
    localparam logic [2:0] S_INS  = 3'd2;  // compare and shift one entry
    localparam logic [2:0] S_PUT  = 3'd3;  // new entry goes to the head slot
    localparam logic [2:0] S_HOLD = 3'd4;  // result waits for the output register

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] a);
        ring_next = (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] a);
        ring_prev = (a == '0) ? LAST_ADDR : a - AW'(1);
    endfunction

    // Control registers.
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg,  head_next;
    logic [AW-1:0] tail_reg,  tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] left_reg,  left_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [AW-1:0]       pos_reg, pos_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [SW-1:0] out_status_reg, out_status_next;
    logic [FW-1:0] out_handle_reg, out_handle_next;
    logic [FW-1:0] out_prio_reg,   out_prio_next;
    logic [OW-1:0] out_occ_reg,    out_occ_next;
    logic [SW-1:0] pend_status_reg, pend_status_next;
    logic [FW-1:0] pend_handle_reg, pend_handle_next;
    logic [FW-1:0] pend_prio_reg,   pend_prio_next;
    logic [OW-1:0] pend_occ_reg,    pend_occ_next;

    // RAM port signals.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    // One finished result per cycle at most.
    logic          done;
    logic [SW-1:0] done_status;
    logic [FW-1:0] done_handle;
    logic [FW-1:0] done_prio;
    logic [OW-1:0] done_occ;

    logic                   accept;
    logic                   out_free;
    logic [KEY_BITS-1:0]    in_key;
    logic [HANDLE_BITS-1:0] in_hnd;
    logic [KEY_BITS-1:0]    rd_key;
    logic [HANDLE_BITS-1:0] rd_hnd;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign in_key = KEY_BITS'(s_tdata[FW-1:0]);
    assign in_hnd = HANDLE_BITS'(s_tdata[2*FW-1:FW]);
    assign rd_key = rd_data[KEY_BITS-1:0];
    assign rd_hnd = rd_data[EW-1:KEY_BITS];

    smpq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        hnd_next    = hnd_reg;

        wr_en   = 1'b0;
        wr_addr = tail_reg;
        wr_data = {hnd_reg, key_reg};
        rd_en   = 1'b0;
        rd_addr = head_reg;

        done        = 1'b0;
        done_status = smpq_pkg::ST_OK;
        done_handle = '0;
        done_prio   = '0;
        done_occ    = OW'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == smpq_pkg::MODE_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            done        = 1'b1;
                            done_status = smpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_POP;
                        end
                    end
                    else if (count_reg == FULL_CNT)
                    begin
                        done        = 1'b1;
                        done_status = smpq_pkg::ST_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty queue: the new entry goes straight to the tail.
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        wr_data    = {in_hnd, in_key};
                        tail_next  = ring_next(tail_reg);
                        count_next = count_reg + CW'(1);
                        done       = 1'b1;
                        done_occ   = OW'(count_next);
                    end
                    else
                    begin
                        key_next   = in_key;
                        hnd_next   = in_hnd;
                        rd_en      = 1'b1;
                        rd_addr    = ring_prev(tail_reg);
                        pos_next   = ring_prev(tail_reg);
                        left_next  = count_reg;
                        state_next = S_INS;
                    end
                end
            end

            S_POP:
            begin
                head_next   = ring_next(head_reg);
                count_next  = count_reg - CW'(1);
                done        = 1'b1;
                done_handle = FW'(rd_hnd);
                done_prio   = FW'(rd_key);
                done_occ    = OW'(count_next);
            end

            S_INS:
            begin
                if (rd_key > key_reg)
                begin
                    // Larger key moves one slot toward the tail.
                    wr_en   = 1'b1;
                    wr_addr = ring_next(pos_reg);
                    wr_data = rd_data;
                    if (left_reg == CW'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = ring_prev(pos_reg);
                        pos_next  = ring_prev(pos_reg);
                        left_next = left_reg - CW'(1);
                    end
                end
                else
                begin
                    // Equal or smaller key stays ahead of the new entry.
                    wr_en      = 1'b1;
                    wr_addr    = ring_next(pos_reg);
                    wr_data    = {hnd_reg, key_reg};
                    tail_next  = ring_next(tail_reg);
                    count_next = count_reg + CW'(1);
                    done       = 1'b1;
                    done_occ   = OW'(count_next);
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = {hnd_reg, key_reg};
                tail_next  = ring_next(tail_reg);
                count_next = count_reg + CW'(1);
                done       = 1'b1;
                done_occ   = OW'(count_next);
            end

            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result delivery: straight into the output register when it is free,
        // otherwise into the pending register until it is.
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_handle_next  = out_handle_reg;
        out_prio_next    = out_prio_reg;
        out_occ_next     = out_occ_reg;
        pend_status_next = pend_status_reg;
        pend_handle_next = pend_handle_reg;
        pend_prio_next   = pend_prio_reg;
        pend_occ_next    = pend_occ_reg;

        if (state_reg == S_HOLD)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_status_next = pend_status_reg;
                out_handle_next = pend_handle_reg;
                out_prio_next   = pend_prio_reg;
                out_occ_next    = pend_occ_reg;
            end
        end
        else if (done)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_status_next = done_status;
                out_handle_next = done_handle;
                out_prio_next   = done_prio;
                out_occ_next    = done_occ;
                state_next      = S_IDLE;
            end
            else
            begin
                pend_status_next = done_status;
                pend_handle_next = done_handle;
                pend_prio_next   = done_prio;
                pend_occ_next    = done_occ;
                state_next       = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        key_reg         <= key_next;
        hnd_reg         <= hnd_next;
        out_status_reg  <= out_status_next;
        out_handle_reg  <= out_handle_next;
        out_prio_reg    <= out_prio_next;
        out_occ_reg     <= out_occ_next;
        pend_status_reg <= pend_status_next;
        pend_handle_reg <= pend_handle_next;
        pend_prio_reg   <= pend_prio_next;
        pend_occ_reg    <= pend_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_prio_reg, out_handle_reg};

endmodule

`default_nettype wire

// ----- design/smpq_checker.sv -----
// ============================================================================
// smpq_checker
// Port-level checks on the result stream of the priority queue.
// ============================================================================
`default_nettype none

module smpq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    localparam logic [4:0] FULL_OCC = 5'(QUEUE_DEPTH);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A pop on an empty queue can only leave an empty queue.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == smpq_pkg::ST_EMPTY) |-> (m_tdata[36:32] == 5'd0))
        else $error("empty status with nonzero occupancy");

    // A refused insert reports a full queue.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == smpq_pkg::ST_FULL) |-> (m_tdata[36:32] == FULL_OCC))
        else $error("full status with wrong occupancy");

    // Refused requests carry no entry.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != smpq_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("error result carries entry data");

endmodule

bind stable_min_priority_queue smpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_smpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- bench/tb_stable_min_priority_queue.sv -----
// ============================================================================
// tb_stable_min_priority_queue
// Self-checking bench for the stable minimum priority queue: a sorted-list
// model of the queue predicts every response, and a scoreboard compares the
// responses field by field under random stalls on both stream ports.
// ============================================================================
`default_nettype none

module tb_stable_min_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_REQUESTS = 900;
    // Longest insert walks the whole ring; this idle tail is sized to cover it.
    localparam int DRAIN_CYCLES = 40;

    // One held entry of the queue, and one predicted response.
    typedef struct packed {
        logic [smpq_pkg::FIELD_BITS-1:0] key;
        logic [smpq_pkg::FIELD_BITS-1:0] handle;
    } queue_entry_t;

    typedef struct packed {
        logic [smpq_pkg::STATUS_BITS-1:0] status;
        logic [smpq_pkg::FIELD_BITS-1:0]  handle;
        logic [smpq_pkg::FIELD_BITS-1:0]  key;
        logic [smpq_pkg::OCC_BITS-1:0]    occupancy;
    } queue_response_t;

    // The scoreboard keeps its own sorted copy of the queue contents. Each
    // accepted request updates that copy and queues the response it must
    // produce; each accepted response is compared with the oldest one.
    class queue_scoreboard_t;
        queue_entry_t    held[$];
        queue_response_t awaited[$];
        int              errors = 0;

        function void note_request(logic mode, logic [smpq_pkg::FIELD_BITS-1:0] key,
                                   logic [smpq_pkg::FIELD_BITS-1:0] handle);
            queue_response_t resp;
            queue_entry_t    entry;
            int              slot;
            resp = '0;
            resp.status = smpq_pkg::ST_OK;
            if (mode == smpq_pkg::MODE_INSERT)
            begin
                if (held.size() >= QUEUE_DEPTH)
                begin
                    resp.status = smpq_pkg::ST_FULL;
                end
                else
                begin
                    // Stability: the new entry goes behind every equal key.
                    slot = held.size();
                    while (slot > 0 && held[slot-1].key > key)
                        slot--;
                    entry.key = key;
                    entry.handle = handle;
                    held.insert(slot, entry);
                end
            end
            else
            begin
                if (held.size() == 0)
                begin
                    resp.status = smpq_pkg::ST_EMPTY;
                end
                else
                begin
                    entry = held.pop_front();
                    resp.handle = entry.handle;
                    resp.key = entry.key;
                end
            end
            resp.occupancy = smpq_pkg::OCC_BITS'(held.size());
            awaited.push_back(resp);
        endfunction

        function void check_response(logic [smpq_pkg::STATUS_BITS-1:0] status,
                                     logic [smpq_pkg::FIELD_BITS-1:0] handle,
                                     logic [smpq_pkg::FIELD_BITS-1:0] key,
                                     logic [smpq_pkg::OCC_BITS-1:0] occupancy);
            queue_response_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: response with none pending: expected nothing, actual %0d %h %h %0d",
                         $time, status, handle, key, occupancy);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (handle !== want.handle)
            begin
                $display("%0t: out_handle mismatch: expected %h, actual %h",
                         $time, want.handle, handle);
                errors++;
            end
            if (key !== want.key)
            begin
                $display("%0t: out_priority mismatch: expected %h, actual %h",
                         $time, want.key, key);
                errors++;
            end
            if (occupancy !== want.occupancy)
            begin
                $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                         $time, want.occupancy, occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata, lowest bit up: priority_req[15:0], item_handle[31:16]
    logic [31:0] s_tdata = '0;
    // s_tuser: mode[0]
    logic [0:0]  s_tuser = smpq_pkg::MODE_INSERT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata, lowest bit up: out_handle[15:0], out_priority[31:16],
    // occupancy[36:32], zero fill[39:37]
    logic [39:0] m_tdata;
    // m_tuser: status[1:0]
    logic [1:0]  m_tuser;

    // When set, the matching side runs without idle cycles for a while.
    bit sender_eager = 1'b0;
    bit receiver_eager = 1'b0;

    queue_scoreboard_t board = new();

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    stable_min_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (smpq_pkg::FIELD_BITS),
        .HANDLE_BITS (smpq_pkg::FIELD_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Monitor. Both handshakes are sampled at the rising edge, where every
    // driven input still holds its value from before the edge. A request
    // noted here can never have its response at the same edge, so noting
    // first and checking second is safe.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_request(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
        if (rst_n && m_tvalid && m_tready)
            board.check_response(m_tuser, m_tdata[15:0], m_tdata[31:16],
                                 m_tdata[36:32]);
    end

    // ------------------------------------------------------------------------
    // Request driver. The task returns at the edge where the request was
    // taken, leaving s_tvalid high; the next call either keeps it high
    // (back-to-back) or drops it for its idle gap, so each edge sees only one
    // assignment to s_tvalid.
    // ------------------------------------------------------------------------
    task automatic send_request(logic mode, logic [smpq_pkg::FIELD_BITS-1:0] key,
                                logic [smpq_pkg::FIELD_BITS-1:0] handle);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {handle, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops sending and waits until every outstanding response has come.
    // The first edge lets the monitor note the request taken just before.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Keys are drawn mostly from a narrow band so that equal priorities are
    // common and stability is really exercised; the rest span the full range.
    function automatic logic [smpq_pkg::FIELD_BITS-1:0] draw_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return smpq_pkg::FIELD_BITS'($urandom_range(0, 7));
        else if (pick == 5)
            return 16'h0000;
        else if (pick == 6)
            return 16'hFFFF;
        else
            return smpq_pkg::FIELD_BITS'($urandom_range(0, 65535));
    endfunction

    // ------------------------------------------------------------------------
    // Response acceptor: a random stall before each response, with runs of
    // no stalling at all picked every few dozen responses.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 32 == 0)
                receiver_eager = ($urandom_range(0, 3) == 0);
            gap = receiver_eager ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        // Sixteen inserts fill the queue exactly. They include both key
        // extremes, ties at the bottom, middle and top of the key range, and
        // both handle extremes.
        logic [smpq_pkg::FIELD_BITS-1:0] fill_keys[QUEUE_DEPTH] = '{
            16'h8000, 16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h0000,
            16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFE,
            16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000
        };
        logic [smpq_pkg::FIELD_BITS-1:0] fill_handles[QUEUE_DEPTH] = '{
            16'h0001, 16'hFFFF, 16'h0000, 16'h0002, 16'h0003, 16'hA5A5,
            16'h1234, 16'h5A5A, 16'h00FF, 16'hFF00, 16'h8000, 16'h7FFF,
            16'hAAAA, 16'h5555, 16'hFFFE, 16'h0F0F
        };
        int insert_odds;
        logic mode;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a pop on the empty queue, a full fill, an insert that
        // must be refused, a few pops from the front, and a tie inserted
        // after partial draining.
        send_request(smpq_pkg::MODE_POP, 16'h0000, 16'h0000);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(smpq_pkg::MODE_INSERT, fill_keys[i], fill_handles[i]);
        send_request(smpq_pkg::MODE_INSERT, 16'h0000, 16'hDEAD);
        repeat (4) send_request(smpq_pkg::MODE_POP, 16'hFFFF, 16'hFFFF);
        send_request(smpq_pkg::MODE_INSERT, 16'h8000, 16'hC3C3);
        send_request(smpq_pkg::MODE_POP, 16'h0000, 16'h0000);

        // Random part. The mix of inserts and pops changes every block of
        // requests, so the queue is driven to full and to empty again and
        // again. Key and handle fields of pops carry random noise as well.
        insert_odds = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 60 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: insert_odds = 10;
                    1: insert_odds = 30;
                    2: insert_odds = 50;
                    3: insert_odds = 75;
                    default: insert_odds = 92;
                endcase
                sender_eager = ($urandom_range(0, 3) == 0);
            end
            // Once, halfway through, hold off until the queue has answered
            // every request so far.
            if (n == RANDOM_REQUESTS / 2)
                wait_until_drained();
            mode = ($urandom_range(1, 100) <= insert_odds) ?
                   smpq_pkg::MODE_INSERT : smpq_pkg::MODE_POP;
            send_request(mode, draw_key(),
                         smpq_pkg::FIELD_BITS'($urandom_range(0, 65535)));
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
